[hw/rtl/lcats_pkg.sv]
// Shared constants, codes and types of the load cell ADC reader with tare and scaling.
package lcats_pkg;

   // Conversion and timing constants.
   localparam int SAMPLE_BITS       = 24;
   localparam int TARE_READS        = 5;
   localparam int HALF_PERIOD_TICKS = 1;

   localparam int RAW_W     = 24;
   localparam int GAIN_W    = 2;
   localparam int SCALE_W   = 16;
   localparam int LIMIT_W   = 24;
   localparam int ACTION_W  = 2;
   localparam int DELAY_W   = 8;
   localparam int BIT_CNT_W = $clog2(SAMPLE_BITS + 1);
   localparam int READS_W   = $clog2(TARE_READS + 1);

   localparam logic [DELAY_W-1:0] HALF_RELOAD = DELAY_W'(HALF_PERIOD_TICKS - 1);

   // Divider: quotient bits, divisor width (20 * scale), remainder width and
   // step counter width. The remainder is wider than the divisor, which follows
   // the live scale setting, so a scale change during a division alters the quotient.
   localparam int QUOT_BITS = 33;
   localparam int QUOT_W    = QUOT_BITS;
   localparam int DIV_W     = SCALE_W + 5;
   localparam int REM_W     = 40;
   localparam int STEPS_W   = $clog2(QUOT_BITS + 1);
   localparam int ROUND_MUL = 200;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TARE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_WEIGH = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_TENTHS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WEIGHT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BELOW_TARE = 2'd3;

   localparam logic [GAIN_W-1:0]  GAIN_MODE_RST      = 2'd0;
   localparam logic [SCALE_W-1:0] SCALE_TENTHS_RST   = 16'd7400;
   localparam logic [LIMIT_W-1:0] MAX_WEIGHT_RST     = 24'd5000;
   localparam logic [LIMIT_W-1:0] MAX_BELOW_TARE_RST = 24'd1000;

   // Result stream layout.
   localparam int RSP_W          = 56;
   localparam int RSP_CLOCK_BIT  = 0;
   localparam int RSP_BUSY_BIT   = 1;
   localparam int RSP_DONE_BIT   = 2;
   localparam int RSP_WEIGHT_LSB = 3;
   localparam int RSP_ERROR_BIT  = 27;
   localparam int RSP_RAW_LSB    = 28;
   localparam int REQ_W          = 8;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_mode;
      logic [SCALE_W-1:0] scale_tenths;
      logic [LIMIT_W-1:0] max_weight;
      logic [LIMIT_W-1:0] max_below_tare;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic [QUOT_W-1:0] dividend;
   } div_cmd_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quot_next;
      logic              last;
   } div_stat_type;

   typedef struct packed {
      logic             clock_pin;
      logic             busy_res;
      logic             done_res;
      logic [RAW_W-1:0] weight;
      logic             error;
      logic [RAW_W-1:0] raw_sample;
   } result_type;

endpackage

[hw/rtl/lcats_div.sv]
// Restoring divider that produces one quotient bit per tick.
module lcats_div
   import lcats_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [SCALE_W-1:0] scale_tenths,
   input  div_cmd_type        cmd,
   output div_stat_type       stat
);

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [STEPS_W-1:0] steps_ff, steps_in;

   logic [DIV_W-1:0]   divisor;
   logic [REM_W-1:0]   divisor_ext;
   logic [REM_W-1:0]   rem_shift;
   logic               fits;
   logic [QUOT_W-1:0]  quot_step;
   logic [REM_W-1:0]   rem_step;
   logic [STEPS_W-1:0] steps_dec;

   always_comb begin
      // 20 * scale as 16 * scale + 4 * scale.
      divisor     = {1'b0, scale_tenths, 4'b0000} + {3'b000, scale_tenths, 2'b00};
      divisor_ext = {{(REM_W-DIV_W){1'b0}}, divisor};
      rem_shift   = {rem_ff[REM_W-2:0], quot_ff[QUOT_W-1]};
      fits        = rem_shift >= divisor_ext;
      rem_step    = fits ? (rem_shift - divisor_ext) : rem_shift;
      quot_step   = {quot_ff[QUOT_W-2:0], fits};
      steps_dec   = (steps_ff != '0) ? steps_ff - STEPS_W'(1) : steps_ff;

      stat.quot_next = (steps_ff != '0) ? quot_step : quot_ff;
      stat.last      = (steps_dec == '0);

      rem_in   = rem_ff;
      quot_in  = quot_ff;
      steps_in = steps_ff;
      if (cmd.load) begin
         rem_in   = '0;
         quot_in  = cmd.dividend;
         steps_in = STEPS_W'(QUOT_BITS);
      end else if (cmd.step && (steps_ff != '0)) begin
         rem_in   = rem_step;
         quot_in  = quot_step;
         steps_in = steps_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         quot_ff  <= '0;
         steps_ff <= '0;
      end else begin
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
         steps_ff <= steps_in;
      end
   end

endmodule

[hw/rtl/lcats_ctrl.sv]
// Tick sequencer for the ADC pins, tare and weigh actions, and result assembly.
module lcats_ctrl
   import lcats_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  logic [ACTION_W-1:0] action,
   input  logic                data_pin,
   input  cfg_type             cfg,
   input  div_stat_type        div_stat,
   output div_cmd_type         div_cmd,
   output result_type          result
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_WAIT    = 3'd1;
   localparam logic [2:0] PH_BIT_HI  = 3'd2;
   localparam logic [2:0] PH_BIT_LO  = 3'd3;
   localparam logic [2:0] PH_GAIN_HI = 3'd4;
   localparam logic [2:0] PH_GAIN_LO = 3'd5;
   localparam logic [2:0] PH_DIVIDE  = 3'd6;

   logic [2:0]           phase_ff, phase_in;
   logic [ACTION_W-1:0]  pend_ff, pend_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [RAW_W-1:0]     shift_ff, shift_in;
   logic [RAW_W-1:0]     tare_ff, tare_in;
   logic [READS_W-1:0]   reads_ff, reads_in;
   logic [RAW_W-1:0]     weight_ff, weight_in;
   logic                 error_ff, error_in;

   logic                 clk_lvl;
   logic                 done;
   logic                 above;
   logic                 below;
   logic                 over;
   logic [RAW_W-1:0]     diff_up;
   logic [RAW_W-1:0]     diff_down;
   logic [QUOT_W-1:0]    scaled;
   logic [QUOT_W-1:0]    net;
   logic [GAIN_W-1:0]    gain_sel;
   logic [BIT_CNT_W-1:0] pulses;
   logic [READS_W-1:0]   reads_inc;

   always_comb begin
      above     = shift_ff > tare_ff;
      diff_up   = shift_ff - tare_ff;
      diff_down = tare_ff - shift_ff;
      // Dividend: 200 * (raw - tare) + scale, for a quotient in whole units.
      scaled    = {{(QUOT_W-RAW_W){1'b0}}, diff_up} * QUOT_W'(ROUND_MUL)
                  + {{(QUOT_W-SCALE_W){1'b0}}, cfg.scale_tenths};
      net       = above ? div_stat.quot_next : '0;
      over      = net > {{(QUOT_W-LIMIT_W){1'b0}}, cfg.max_weight};
      below     = (shift_ff < tare_ff) && (diff_down > cfg.max_below_tare);
      gain_sel  = (cfg.gain_mode > 2'd2) ? 2'd2 : cfg.gain_mode;
      pulses    = BIT_CNT_W'(gain_sel) + BIT_CNT_W'(1);
      reads_inc = reads_ff + READS_W'(1);

      phase_in   = phase_ff;
      pend_in    = pend_ff;
      bit_cnt_in = bit_cnt_ff;
      delay_in   = delay_ff;
      shift_in   = shift_ff;
      tare_in    = tare_ff;
      reads_in   = reads_ff;
      weight_in  = weight_ff;
      error_in   = error_ff;
      clk_lvl    = 1'b0;
      done       = 1'b0;

      div_cmd.load     = 1'b0;
      div_cmd.step     = 1'b0;
      div_cmd.dividend = above ? scaled : '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if ((action == ACT_TARE) || (action == ACT_WEIGH)) begin
               pend_in  = action;
               reads_in = '0;
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            // The ADC pulls its data line low when a conversion is ready.
            if (!data_pin) begin
               shift_in   = '0;
               bit_cnt_in = '0;
               delay_in   = HALF_RELOAD;
               phase_in   = PH_BIT_HI;
               clk_lvl    = 1'b1;
            end
         end
         PH_BIT_HI: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - DELAY_W'(1);
               clk_lvl  = 1'b1;
            end else begin
               shift_in   = {shift_ff[RAW_W-2:0], data_pin};
               bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
               delay_in   = HALF_RELOAD;
               phase_in   = PH_BIT_LO;
            end
         end
         PH_BIT_LO: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - DELAY_W'(1);
            end else if (bit_cnt_ff < BIT_CNT_W'(SAMPLE_BITS)) begin
               delay_in = HALF_RELOAD;
               phase_in = PH_BIT_HI;
               clk_lvl  = 1'b1;
            end else begin
               bit_cnt_in = '0;
               delay_in   = HALF_RELOAD;
               phase_in   = PH_GAIN_HI;
               clk_lvl    = 1'b1;
            end
         end
         PH_GAIN_HI: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - DELAY_W'(1);
               clk_lvl  = 1'b1;
            end else begin
               bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
               delay_in   = HALF_RELOAD;
               phase_in   = PH_GAIN_LO;
            end
         end
         PH_GAIN_LO: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - DELAY_W'(1);
            end else if (bit_cnt_ff < pulses) begin
               delay_in = HALF_RELOAD;
               phase_in = PH_GAIN_HI;
               clk_lvl  = 1'b1;
            end else if (pend_ff == ACT_TARE) begin
               tare_in  = shift_ff;
               reads_in = reads_inc;
               if (reads_inc >= READS_W'(TARE_READS)) begin
                  error_in = 1'b0;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_WAIT;
               end
            end else begin
               div_cmd.load = tick;
               phase_in     = PH_DIVIDE;
            end
         end
         PH_DIVIDE: begin
            div_cmd.step = tick;
            if (div_stat.last) begin
               weight_in = (net[QUOT_W-1:RAW_W] != '0) ? '1 : net[RAW_W-1:0];
               error_in  = over || below;
               phase_in  = PH_IDLE;
               done      = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      result.clock_pin  = clk_lvl;
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.weight     = weight_in;
      result.error      = done && error_in;
      result.raw_sample = shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pend_ff    <= ACT_NONE;
         bit_cnt_ff <= '0;
         delay_ff   <= '0;
         shift_ff   <= '0;
         tare_ff    <= '0;
         reads_ff   <= '0;
         weight_ff  <= '0;
         error_ff   <= 1'b0;
      end else if (tick) begin
         phase_ff   <= phase_in;
         pend_ff    <= pend_in;
         bit_cnt_ff <= bit_cnt_in;
         delay_ff   <= delay_in;
         shift_ff   <= shift_in;
         tare_ff    <= tare_in;
         reads_ff   <= reads_in;
         weight_ff  <= weight_in;
         error_ff   <= error_in;
      end
   end

endmodule

[hw/rtl/load_cell_adc_reader_tare_scale.sv]
// Top level of the load cell ADC reader: stream stages, configuration and core.
//
// Each request transaction is one tick of the ADC pin interface: it carries the
// action requested on that tick and the sampled level of the ADC data line. Each
// tick yields exactly one response transaction with the serial clock level to
// drive, busy and done flags, the held weight, the error flag and the raw sample.
// Configuration writes on the csr channel set gain mode, scale in tenths and the
// two error limits; csr_ready is always high.
// The block takes one request per cycle while the receiver is not stalling.
// A request is captured in an input register and processed when the output
// register is empty or being read, which loads its response into that register.
// A weigh action lasts one conversion (wait for data low, then 24 data pulses
// plus gain pulses on the ADC clock) followed by a 33-bit division, one
// quotient bit per tick; a tare action lasts five conversions.
// Reset empties both stream stages, returns the sequencer to idle with the ADC
// clock low, clears tare and held results, and loads the register defaults.
// When the receiver stalls, the response is held and the input register fills;
// request acceptance stops until the response is taken.
module load_cell_adc_reader_tare_scale
   import lcats_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // action[1:0], data_pin[2], zero[7:3]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // clock_pin[0], busy_res[1], done_res[2],
                                             // weight[26:3], error[27], raw_sample[51:28],
                                             // zero[55:52]
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0] in_action_ff;
   logic                in_pin_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_ff;
   cfg_type             cfg_ff, cfg_in;

   logic                tick;
   logic                req_take;
   result_type          result;
   div_cmd_type         div_cmd;
   div_stat_type        div_stat;

   assign tick       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || tick;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !tick);
      out_valid_in = tick || (out_valid_ff && !rsp_tready);

      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_MODE:      cfg_in.gain_mode      = csr_data[GAIN_W-1:0];
            CSR_SCALE_TENTHS:   cfg_in.scale_tenths   = csr_data[SCALE_W-1:0];
            CSR_MAX_WEIGHT:     cfg_in.max_weight     = csr_data;
            CSR_MAX_BELOW_TARE: cfg_in.max_below_tare = csr_data;
            default:            cfg_in                = cfg_ff;
         endcase
      end

      rsp_tdata = '0;
      rsp_tdata[RSP_CLOCK_BIT]                   = out_ff.clock_pin;
      rsp_tdata[RSP_BUSY_BIT]                    = out_ff.busy_res;
      rsp_tdata[RSP_DONE_BIT]                    = out_ff.done_res;
      rsp_tdata[RSP_WEIGHT_LSB +: RAW_W]         = out_ff.weight;
      rsp_tdata[RSP_ERROR_BIT]                   = out_ff.error;
      rsp_tdata[RSP_RAW_LSB +: RAW_W]            = out_ff.raw_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         cfg_ff.gain_mode      <= GAIN_MODE_RST;
         cfg_ff.scale_tenths   <= SCALE_TENTHS_RST;
         cfg_ff.max_weight     <= MAX_WEIGHT_RST;
         cfg_ff.max_below_tare <= MAX_BELOW_TARE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tdata[ACTION_W-1:0];
         in_pin_ff    <= req_tdata[ACTION_W];
      end
      if (tick) begin
         out_ff <= result;
      end
   end

   lcats_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .action   (in_action_ff),
      .data_pin (in_pin_ff),
      .cfg      (cfg_ff),
      .div_stat (div_stat),
      .div_cmd  (div_cmd),
      .result   (result)
   );

   lcats_div u_div (
      .clock        (clock),
      .reset        (reset),
      .scale_tenths (cfg_ff.scale_tenths),
      .cmd          (div_cmd),
      .stat         (div_stat)
   );

endmodule

[hw/rtl/lcats_check.sv]
// Port-level assertions for the load cell ADC reader and the bind that attaches them.
module lcats_check
   import lcats_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // No response may be presented right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // An action never reports completion while still busy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_DONE_BIT]) |-> !rsp_tdata[RSP_BUSY_BIT])
      else $error("done reported while busy");

   // The error flag only appears together with done.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_ERROR_BIT]) |-> rsp_tdata[RSP_DONE_BIT])
      else $error("error without done");

   // The ADC clock is only driven high during an action.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_CLOCK_BIT]) |-> rsp_tdata[RSP_BUSY_BIT])
      else $error("ADC clock high while idle");

endmodule

bind load_cell_adc_reader_tare_scale lcats_check u_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/weigh_tick_checker.sv]
// Tick-level predictor and response checker for the load cell ADC reader.
`timescale 1ns / 100ps

module weigh_tick_checker
   import lcats_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data,
   output int unsigned          mismatch_count,
   output int unsigned          pending_count,
   output logic                 sequencer_idle
);

   localparam int DIVISOR_MUL = 20;
   localparam logic [DELAY_W-1:0] HALF_LOAD = DELAY_W'(HALF_PERIOD_TICKS - 1);

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_WAIT,
      SEQ_BIT_HIGH,
      SEQ_BIT_LOW,
      SEQ_GAIN_HIGH,
      SEQ_GAIN_LOW,
      SEQ_DIVIDE
   } seq_phase_type;

   typedef struct {
      logic             clock_pin;
      logic             busy;
      logic             done;
      logic [RAW_W-1:0] weight;
      logic             error;
      logic [RAW_W-1:0] raw;
   } tick_result_type;

   // Configuration copy.
   logic [GAIN_W-1:0]  gain_cfg;
   logic [SCALE_W-1:0] scale_cfg;
   logic [LIMIT_W-1:0] max_weight_cfg;
   logic [LIMIT_W-1:0] max_below_cfg;

   // Sequencer copy.
   seq_phase_type      phase;
   logic [ACTION_W-1:0] pending_act;
   int unsigned        bits_taken;
   logic [DELAY_W-1:0] half_count;
   logic [RAW_W-1:0]   shift_reg;
   logic [RAW_W-1:0]   tare_reg;
   logic [2:0]         reads_count;
   logic [39:0]        div_rem;
   logic [32:0]        div_quot;
   logic [5:0]         steps_left;
   logic [RAW_W-1:0]   weight_reg;
   logic               error_reg;

   tick_result_type expected_ticks[$];
   int unsigned     fail_tally = 0;

   assign mismatch_count = fail_tally;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      fail_tally++;
   endtask

   task automatic clear_sequencer();
      gain_cfg       = GAIN_MODE_RST;
      scale_cfg      = SCALE_TENTHS_RST;
      max_weight_cfg = MAX_WEIGHT_RST;
      max_below_cfg  = MAX_BELOW_TARE_RST;
      phase          = SEQ_IDLE;
      pending_act    = ACT_NONE;
      bits_taken     = 0;
      half_count     = '0;
      shift_reg      = '0;
      tare_reg       = '0;
      reads_count    = '0;
      div_rem        = '0;
      div_quot       = '0;
      steps_left     = '0;
      weight_reg     = '0;
      error_reg      = 1'b0;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [LIMIT_W-1:0] value);
      case (idx)
         CSR_GAIN_MODE:      gain_cfg       = value[GAIN_W-1:0];
         CSR_SCALE_TENTHS:   scale_cfg      = value[SCALE_W-1:0];
         CSR_MAX_WEIGHT:     max_weight_cfg = value;
         CSR_MAX_BELOW_TARE: max_below_cfg  = value;
         default: ;
      endcase
   endtask

   // A finished conversion either counts toward the tare or starts the division.
   task automatic close_conversion(output logic done);
      logic [63:0] dividend;
      done = 1'b0;
      if (pending_act == ACT_TARE) begin
         tare_reg    = shift_reg;
         reads_count = reads_count + 3'd1;
         if (int'(reads_count) >= TARE_READS) begin
            error_reg = 1'b0;
            phase     = SEQ_IDLE;
            done      = 1'b1;
         end else begin
            phase = SEQ_WAIT;
         end
      end else begin
         dividend = '0;
         if (shift_reg > tare_reg)
            dividend = 64'(shift_reg - tare_reg) * 64'(ROUND_MUL) + 64'(scale_cfg);
         div_quot   = dividend[32:0];
         div_rem    = '0;
         steps_left = 6'(QUOT_BITS);
         phase      = SEQ_DIVIDE;
      end
   endtask

   task automatic advance_sequencer(input logic [ACTION_W-1:0] act, input logic pin,
                                    output tick_result_type res);
      logic        clk;
      logic        done;
      int unsigned pulses;
      logic [39:0] divisor;
      logic [32:0] net_quot;
      logic        over;
      logic        below;
      clk    = 1'b0;
      done   = 1'b0;
      pulses = (gain_cfg > 2'd2) ? 3 : int'(gain_cfg) + 1;
      case (phase)
         SEQ_IDLE: begin
            if (act == ACT_TARE || act == ACT_WEIGH) begin
               pending_act = act;
               reads_count = '0;
               phase       = SEQ_WAIT;
            end
         end
         SEQ_WAIT: begin
            if (!pin) begin
               shift_reg  = '0;
               bits_taken = 0;
               half_count = HALF_LOAD;
               phase      = SEQ_BIT_HIGH;
               clk        = 1'b1;
            end
         end
         SEQ_BIT_HIGH: begin
            if (half_count != 0) begin
               half_count--;
               clk = 1'b1;
            end else begin
               shift_reg  = {shift_reg[RAW_W-2:0], pin};
               bits_taken++;
               half_count = HALF_LOAD;
               phase      = SEQ_BIT_LOW;
            end
         end
         SEQ_BIT_LOW: begin
            if (half_count != 0) begin
               half_count--;
            end else if (bits_taken < SAMPLE_BITS) begin
               half_count = HALF_LOAD;
               phase      = SEQ_BIT_HIGH;
               clk        = 1'b1;
            end else begin
               bits_taken = 0;
               half_count = HALF_LOAD;
               phase      = SEQ_GAIN_HIGH;
               clk        = 1'b1;
            end
         end
         SEQ_GAIN_HIGH: begin
            if (half_count != 0) begin
               half_count--;
               clk = 1'b1;
            end else begin
               bits_taken++;
               half_count = HALF_LOAD;
               phase      = SEQ_GAIN_LOW;
            end
         end
         SEQ_GAIN_LOW: begin
            if (half_count != 0) begin
               half_count--;
            end else if (bits_taken < pulses) begin
               half_count = HALF_LOAD;
               phase      = SEQ_GAIN_HIGH;
               clk        = 1'b1;
            end else begin
               close_conversion(done);
            end
         end
         SEQ_DIVIDE: begin
            // Restoring division, one quotient bit per tick, scale read live.
            if (steps_left != 0) begin
               divisor  = 40'(scale_cfg) * 40'(DIVISOR_MUL);
               div_rem  = {div_rem[38:0], div_quot[32]};
               div_quot = {div_quot[31:0], 1'b0};
               if (div_rem >= divisor) begin
                  div_rem     = div_rem - divisor;
                  div_quot[0] = 1'b1;
               end
               steps_left--;
            end
            if (steps_left == 0) begin
               net_quot   = (shift_reg > tare_reg) ? div_quot : '0;
               over       = net_quot > 33'(max_weight_cfg);
               below      = (shift_reg < tare_reg) && ((tare_reg - shift_reg) > max_below_cfg);
               weight_reg = (net_quot > 33'h0FF_FFFF) ? '1 : net_quot[RAW_W-1:0];
               error_reg  = over || below;
               phase      = SEQ_IDLE;
               done       = 1'b1;
            end
         end
         default: phase = SEQ_IDLE;
      endcase
      res.clock_pin = clk;
      res.busy      = (phase != SEQ_IDLE);
      res.done      = done;
      res.weight    = weight_reg;
      res.error     = done ? error_reg : 1'b0;
      res.raw       = shift_reg;
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      tick_result_type got;
      if (reset) begin
         clear_sequencer();
         expected_ticks.delete();
      end else begin
         // Responses first: a response never belongs to a request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got.clock_pin = rsp_tdata[RSP_CLOCK_BIT];
            got.busy      = rsp_tdata[RSP_BUSY_BIT];
            got.done      = rsp_tdata[RSP_DONE_BIT];
            got.weight    = rsp_tdata[RSP_WEIGHT_LSB +: RAW_W];
            got.error     = rsp_tdata[RSP_ERROR_BIT];
            got.raw       = rsp_tdata[RSP_RAW_LSB +: RAW_W];
            if (expected_ticks.size() == 0) begin
               report_mismatch("response with no request pending", 64'(rsp_tdata), '0);
            end else begin
               want = expected_ticks.pop_front();
               if (got.clock_pin !== want.clock_pin)
                  report_mismatch("clock_pin", 64'(got.clock_pin), 64'(want.clock_pin));
               if (got.busy !== want.busy)
                  report_mismatch("busy_res", 64'(got.busy), 64'(want.busy));
               if (got.done !== want.done)
                  report_mismatch("done_res", 64'(got.done), 64'(want.done));
               if (got.weight !== want.weight)
                  report_mismatch("weight", 64'(got.weight), 64'(want.weight));
               if (got.error !== want.error)
                  report_mismatch("error", 64'(got.error), 64'(want.error));
               if (got.raw !== want.raw)
                  report_mismatch("raw_sample", 64'(got.raw), 64'(want.raw));
            end
         end
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_data);
         if (req_tvalid && req_tready) begin
            advance_sequencer(req_tdata[ACTION_W-1:0], req_tdata[ACTION_W], want);
            expected_ticks.push_back(want);
         end
      end
      pending_count  <= expected_ticks.size();
      sequencer_idle <= (phase == SEQ_IDLE);
   end

endmodule

[sim/testbench.sv]
// Stimulus and verdict for the load cell ADC reader with tare and scaling.
`timescale 1ns / 100ps

module testbench;
   import lcats_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [RAW_W-1:0] TARE_MID = 24'h40_0000;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_GAIN_MODE;
   logic [LIMIT_W-1:0]   csr_data   = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   logic        sequencer_idle;

   int unsigned cycle_count   = 0;
   int unsigned stall_left    = 0;
   logic        rsp_stall_on  = 1'b0;
   logic        req_gaps_on   = 1'b0;
   int unsigned ticks_sent    = 0;

   // What the stimulus knows of the block's setup and tare.
   logic [GAIN_W-1:0]  cur_gain   = GAIN_MODE_RST;
   logic [SCALE_W-1:0] cur_scale  = SCALE_TENTHS_RST;
   logic [LIMIT_W-1:0] cur_heavy  = MAX_WEIGHT_RST;
   logic [LIMIT_W-1:0] cur_below  = MAX_BELOW_TARE_RST;
   logic [RAW_W-1:0]   tare_raw   = '0;

   load_cell_adc_reader_tare_scale dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   weigh_tick_checker tick_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .sequencer_idle (sequencer_idle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver back-pressure: mostly short stalls, now and then a long one.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 99) < 15) begin
         stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) :
                                                       $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_gaps_on || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Ticks the data line stays high before a conversion may start.
   function automatic int hold_ticks();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(20, 60);
   endfunction

   function automatic logic [RAW_W-1:0] clip_raw(input longint v);
      if (v < 0)
         return '0;
      if (v > longint'(24'hFF_FFFF))
         return '1;
      return RAW_W'(v);
   endfunction

   function automatic logic [RAW_W-1:0] pick_tare_raw();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return TARE_MID + RAW_W'($urandom_range(0, 5000)) - RAW_W'(2500);
         3: return RAW_W'($urandom_range(0, 2000));
         default: return RAW_W'($urandom());
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_weigh_raw();
      longint base;
      longint span;
      base = longint'(tare_raw);
      span = longint'(cur_scale) / 10;
      case ($urandom_range(0, 8))
         0: return tare_raw;
         1: return clip_raw(base + $urandom_range(1, 4000));
         2: return clip_raw(base - $urandom_range(0, cur_below + cur_below / 4 + 2));
         3: return clip_raw(base - longint'(cur_below) - $urandom_range(0, 1));
         4: return clip_raw(base + longint'(cur_heavy) * cur_scale / 10 - span
                            + $urandom_range(0, 2 * span + 2));
         5: return '1;
         6: return '0;
         default: return RAW_W'($urandom());
      endcase
   endfunction

   // Entered and left just after a rising edge.
   task automatic send_tick(input logic [ACTION_W-1:0] act, input logic pin);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({pin, act});
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
   endtask

   // The sequencer is busy on these ticks, so a stray action must be ignored.
   task automatic busy_tick(input logic pin);
      logic [ACTION_W-1:0] act;
      act = ($urandom_range(0, 3) == 0) ? ACTION_W'($urandom_range(0, 3)) : ACT_NONE;
      send_tick(act, pin);
   endtask

   task automatic run_conversion(input logic [RAW_W-1:0] raw, input int hold);
      int pulses;
      repeat (hold) busy_tick(1'b1);
      busy_tick(1'b0);
      for (int i = RAW_W - 1; i >= 0; i--) begin
         busy_tick(raw[i]);
         busy_tick(coin());
      end
      pulses = (cur_gain > 2'd2) ? 3 : int'(cur_gain) + 1;
      repeat (2 * pulses) busy_tick(coin());
   endtask

   task automatic run_tare(input logic [RAW_W-1:0] final_raw);
      send_tick(ACT_TARE, coin());
      for (int n = 0; n < TARE_READS; n++)
         run_conversion((n == TARE_READS - 1) ? final_raw : RAW_W'($urandom()), hold_ticks());
      tare_raw = final_raw;
   endtask

   task automatic run_weigh(input logic [RAW_W-1:0] raw, input int hold);
      send_tick(ACT_WEIGH, coin());
      run_conversion(raw, hold);
      repeat (QUOT_BITS) busy_tick(coin());
   endtask

   // The idle flag is registered, so this may send one spare tick.
   task automatic drain_sequencer();
      while (!sequencer_idle) send_tick(ACT_NONE, coin());
   endtask

   task automatic quiesce();
      drain_sequencer();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [GAIN_W-1:0] gain, input logic [SCALE_W-1:0] scale,
                                 input logic [LIMIT_W-1:0] heavy,
                                 input logic [LIMIT_W-1:0] below);
      quiesce();
      csr_beat(CSR_GAIN_MODE, LIMIT_W'(gain));
      csr_beat(CSR_SCALE_TENTHS, LIMIT_W'(scale));
      csr_beat(CSR_MAX_WEIGHT, heavy);
      csr_beat(CSR_MAX_BELOW_TARE, below);
      csr_valid <= 1'b0;
      cur_gain  = gain;
      cur_scale = scale;
      cur_heavy = heavy;
      cur_below = below;
   endtask

   task automatic set_pace();
      req_gaps_on   = ($urandom_range(0, 3) != 0);
      rsp_stall_on <= ($urandom_range(0, 3) != 0);
   endtask

   task automatic run_batch(input int count);
      set_pace();
      repeat (count) begin
         drain_sequencer();
         case ($urandom_range(0, 9))
            0, 1: begin
               // Noise and broken sequences: any action code, any data line level.
               repeat ($urandom_range(5, 40)) send_tick(ACTION_W'($urandom_range(0, 3)), coin());
            end
            2, 3, 4: run_tare(pick_tare_raw());
            default: run_weigh(pick_weigh_raw(), hold_ticks());
         endcase
      end
   endtask

   initial begin
      logic [SCALE_W-1:0] scale;
      logic [LIMIT_W-1:0] heavy;
      logic [LIMIT_W-1:0] below;
      int                 r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings.
      send_tick(ACT_NONE, 1'b0);
      send_tick(ACT_UNUSED, 1'b1);
      run_weigh(24'h00_12AB, 1);
      run_tare(TARE_MID);
      run_weigh(TARE_MID - 24'd1001, 0);
      // Exactly at the weight limit, then one unit above it.
      run_weigh(TARE_MID + 24'd3_700_000, 0);
      run_weigh(TARE_MID + 24'd3_700_740, 0);

      // Zero scale and the unused gain mode.
      apply_settings(2'd3, 16'd0, 24'd5000, 24'd1000);
      run_weigh(TARE_MID + 24'd5000, 0);

      while (ticks_sent < 800) begin
         r     = $urandom_range(0, 99);
         scale = (r < 15) ? SCALE_W'($urandom_range(1, 50)) :
                 (r < 85) ? SCALE_W'($urandom_range(500, 20000)) :
                            SCALE_W'($urandom_range(1, 65535));
         heavy = ($urandom_range(0, 1) == 0) ? LIMIT_W'($urandom_range(0, 20000)) :
                                               LIMIT_W'($urandom());
         below = ($urandom_range(0, 9) < 6) ? LIMIT_W'($urandom_range(0, 5000)) :
                                              LIMIT_W'($urandom());
         apply_settings(GAIN_W'($urandom_range(0, 3)), scale, heavy, below);
         run_batch($urandom_range(1, 2));
      end

      quiesce();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/lcats_pkg.sv
hw/rtl/lcats_div.sv
hw/rtl/lcats_ctrl.sv
hw/rtl/load_cell_adc_reader_tare_scale.sv
hw/rtl/lcats_check.sv
sim/weigh_tick_checker.sv
sim/testbench.sv
